[src/cia_pkg.sv]
// shared types and constants for the checked integer alu
// no dependencies; used by checked_int64_alu_core, cia_checker and the testbench
package cia_pkg;

	localparam logic [4:0] KIND_ADD  = 5'd0;
	localparam logic [4:0] KIND_SUB  = 5'd1;
	localparam logic [4:0] KIND_MUL  = 5'd2;
	localparam logic [4:0] KIND_DIV  = 5'd3;
	localparam logic [4:0] KIND_REM  = 5'd4;
	localparam logic [4:0] KIND_SHL  = 5'd5;
	localparam logic [4:0] KIND_SAR  = 5'd6;
	localparam logic [4:0] KIND_AND  = 5'd7;
	localparam logic [4:0] KIND_OR   = 5'd8;
	localparam logic [4:0] KIND_XOR  = 5'd9;
	localparam logic [4:0] KIND_NOT  = 5'd10;
	localparam logic [4:0] KIND_EQ   = 5'd11;
	localparam logic [4:0] KIND_NE   = 5'd12;
	localparam logic [4:0] KIND_GT   = 5'd13;
	localparam logic [4:0] KIND_GE   = 5'd14;
	localparam logic [4:0] KIND_LT   = 5'd15;
	localparam logic [4:0] KIND_LE   = 5'd16;
	localparam logic [4:0] KIND_MIN  = 5'd17;
	localparam logic [4:0] KIND_MAX  = 5'd18;
	localparam logic [4:0] KIND_HASH = 5'd19;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_OVF   = 2'd1;
	localparam logic [1:0] ERR_SHIFT = 2'd2;
	localparam logic [1:0] ERR_DIV0  = 2'd3;

	// hash mixing shift counts
	localparam int HASH_SH1 = 15;
	localparam int HASH_SH2 = 10;
	localparam int HASH_SH3 = 3;
	localparam int HASH_SH4 = 6;
	localparam int HASH_SH5 = 11;
	localparam int HASH_SH6 = 16;

	typedef struct packed {
		logic [4:0]         kind;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [63:0] result;
		logic [1:0]         error;
	} out_t;

endpackage

[src/cia_mul.sv]
// three-stage unsigned multiplier on operand magnitudes with overflow flag
// uses no package items; instantiated by checked_int64_alu_core
module cia_mul #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] mag_a,
	input  logic [DATA_WIDTH-1:0] mag_b,
	input  logic                  neg,
	output logic [DATA_WIDTH-1:0] prod,
	output logic                  ovf
);
	localparam int LO = DATA_WIDTH / 2;
	localparam int HI = DATA_WIDTH - LO;
	localparam int PW = 2 * DATA_WIDTH;
	localparam logic [DATA_WIDTH-1:0] SIGN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [2*LO-1:0]  pp_ll_s1;
	logic [LO+HI-1:0] pp_lh_s1;
	logic [LO+HI-1:0] pp_hl_s1;
	logic [2*HI-1:0]  pp_hh_s1;
	logic             neg_s1;
	logic [PW-1:0]    full_s2;
	logic             neg_s2;
	logic [DATA_WIDTH-1:0] lim;

	// partial products on half words
	always_ff @(posedge clk) begin
		pp_ll_s1 <= mag_a[LO-1:0] * mag_b[LO-1:0];
		pp_lh_s1 <= mag_a[LO-1:0] * mag_b[DATA_WIDTH-1:LO];
		pp_hl_s1 <= mag_a[DATA_WIDTH-1:LO] * mag_b[LO-1:0];
		pp_hh_s1 <= mag_a[DATA_WIDTH-1:LO] * mag_b[DATA_WIDTH-1:LO];
		neg_s1   <= neg;
	end

	always_ff @(posedge clk) begin
		full_s2 <= PW'(pp_ll_s1) + (PW'(pp_lh_s1) << LO) + (PW'(pp_hl_s1) << LO)
			+ (PW'(pp_hh_s1) << (2 * LO));
		neg_s2  <= neg_s1;
	end

	// a negative product may reach the magnitude of min
	assign lim = neg_s2 ? SIGN_VAL : SIGN_VAL - 1'b1;

	always_ff @(posedge clk) begin
		ovf  <= (|full_s2[PW-1:DATA_WIDTH]) || (full_s2[DATA_WIDTH-1:0] > lim);
		prod <= neg_s2 ? -full_s2[DATA_WIDTH-1:0] : full_s2[DATA_WIDTH-1:0];
	end

endmodule

[src/cia_div.sv]
// restoring unsigned divider, one quotient bit per pipeline stage
// uses no package items; instantiated by checked_int64_alu_core
module cia_div #(
	parameter int DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic [DATA_WIDTH-1:0] quo,
	output logic [DATA_WIDTH-1:0] rem
);
	logic [DATA_WIDTH-1:0] rem_sp [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_sp [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dvs_sp [0:DATA_WIDTH];

	assign rem_sp[0] = '0;
	assign quo_sp[0] = dividend;
	assign dvs_sp[0] = divisor;

	for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_step
		logic [DATA_WIDTH:0] trial;
		logic                ge;

		// shift in the next dividend bit and try the subtract
		assign trial = {rem_sp[k-1], quo_sp[k-1][DATA_WIDTH-1]};
		assign ge    = trial >= {1'b0, dvs_sp[k-1]};

		always_ff @(posedge clk) begin
			rem_sp[k] <= ge ? DATA_WIDTH'(trial - {1'b0, dvs_sp[k-1]})
				: trial[DATA_WIDTH-1:0];
			quo_sp[k] <= {quo_sp[k-1][DATA_WIDTH-2:0], ge};
			dvs_sp[k] <= dvs_sp[k-1];
		end
	end

	assign quo = quo_sp[DATA_WIDTH];
	assign rem = rem_sp[DATA_WIDTH];

endmodule

[src/checked_int64_alu_core.sv]
// checked signed integer alu: add, sub, mul, div, rem, shifts, logic, compares, min, max, hash
// uses cia_pkg, cia_mul and cia_div
//
// usage:
//   command channel: drive cmd and raise start; a beat is taken at every edge with
//   start high and busy low. busy stays low, so one command enters every cycle.
//   result channel: done is high for exactly one cycle with rsp holding result and
//   error. there is no back pressure; the receiver must take every beat.
//   config channel: cfg_valid/cfg_ready write safe_mode from cfg_data; cfg_ready is
//   always high. write it only when no command is in flight.
//   path: every operation runs through the input registers, the divider stages and the
//   output register, so all share the divider's depth; it resolves one quotient bit per stage.
//   shift amounts are the low bits of operand_b (the width is a power of two).
//   throughput: one command per cycle; results leave in command order.
//   reset: arst_n clears all valid bits and done, and sets safe_mode to 1.
//   errors give a zero result; division by zero is flagged in both modes.
module checked_int64_alu_core #(
	parameter int DATA_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cia_pkg::in_t   cmd,
	output logic           done,
	output cia_pkg::out_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	localparam int W      = DATA_WIDTH;
	localparam int NS     = W + 1;
	localparam int MUL_IX = 5;
	localparam int SA     = $clog2(W);
	localparam logic [W-1:0] W_VAL    = W'(W);
	localparam logic [W-1:0] SIGN_VAL = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [4:0]    kind;
		logic          safe;
		logic          negq;
		logic          negr;
		logic [1:0]    err;
		logic [SA-1:0] shamt;
		logic [W-1:0]  res;
	} side_t;

	function automatic logic [W-1:0] hash_lo(input logic [W-1:0] h);
		logic [W-1:0] t;
		t = h + ~(h << cia_pkg::HASH_SH1);
		t = t ^ (t >> cia_pkg::HASH_SH2);
		t = t + (t << cia_pkg::HASH_SH3);
		return t;
	endfunction

	function automatic logic [W-1:0] hash_hi(input logic [W-1:0] h);
		logic [W-1:0] t;
		t = h ^ (h >> cia_pkg::HASH_SH4);
		t = t + ~(t << cia_pkg::HASH_SH5);
		t = t ^ (t >> cia_pkg::HASH_SH6);
		return t;
	endfunction

	logic         safe_q;
	logic [W-1:0] a, b, ua, ub, sum, dif;
	logic         lt, gt, eq;
	side_t        side_in;
	logic [W-1:0] dvd_in, dvs_in;

	logic [W-1:0] dvd_s1, dvs_s1;
	logic         vld_sp  [1:NS];
	side_t        side_sp [1:NS];
	side_t        side_nx [2:NS];

	logic [W-1:0] mul_prod, quo, rem;
	logic         mul_ovf;
	side_t        fin;
	logic [W-1:0] val;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			safe_q <= cfg_data;
		end
	end

	// decode and combinational operations
	always_comb begin
		a   = cmd.operand_a[W-1:0];
		b   = cmd.operand_b[W-1:0];
		ua  = a[W-1] ? -a : a;
		ub  = b[W-1] ? -b : b;
		sum = a + b;
		dif = a - b;
		lt  = $signed(a) < $signed(b);
		gt  = $signed(b) < $signed(a);
		eq  = a == b;

		side_in.kind  = cmd.kind;
		side_in.safe  = safe_q;
		side_in.negq  = a[W-1] ^ b[W-1];
		side_in.negr  = a[W-1];
		side_in.err   = cia_pkg::ERR_NONE;
		side_in.shamt = b[SA-1:0];
		side_in.res   = '0;
		dvd_in = ua;
		dvs_in = ub;

		case (cmd.kind)
			cia_pkg::KIND_ADD: begin
				side_in.res = sum;
				if (safe_q && (a[W-1] ^ sum[W-1]) && (b[W-1] ^ sum[W-1]))
					side_in.err = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_SUB: begin
				side_in.res = dif;
				if (safe_q && (a[W-1] ^ b[W-1]) && (a[W-1] ^ dif[W-1]))
					side_in.err = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_MUL: side_in.res = '0;
			cia_pkg::KIND_DIV: begin
				if (b == '0)
					side_in.err = cia_pkg::ERR_DIV0;
				else if (safe_q && a == SIGN_VAL && b == '1)
					side_in.err = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_REM: begin
				if (b == '0)
					side_in.err = cia_pkg::ERR_DIV0;
			end
			cia_pkg::KIND_SHL, cia_pkg::KIND_SAR: begin
				side_in.res = a;
				if (safe_q && (b[W-1] || b >= W_VAL))
					side_in.err = cia_pkg::ERR_SHIFT;
			end
			cia_pkg::KIND_AND:  side_in.res = a & b;
			cia_pkg::KIND_OR:   side_in.res = a | b;
			cia_pkg::KIND_XOR:  side_in.res = a ^ b;
			cia_pkg::KIND_NOT:  side_in.res = ~a;
			cia_pkg::KIND_EQ:   side_in.res = W'(eq);
			cia_pkg::KIND_NE:   side_in.res = W'(!eq);
			cia_pkg::KIND_GT:   side_in.res = W'(gt);
			cia_pkg::KIND_GE:   side_in.res = W'(!lt);
			cia_pkg::KIND_LT:   side_in.res = W'(lt);
			cia_pkg::KIND_LE:   side_in.res = W'(!gt);
			cia_pkg::KIND_MIN:  side_in.res = lt ? a : b;
			cia_pkg::KIND_MAX:  side_in.res = gt ? a : b;
			cia_pkg::KIND_HASH: side_in.res = hash_lo(a);
			default:            side_in.res = '0;
		endcase
	end

	cia_mul #(.DATA_WIDTH(W)) u_mul (
		.clk   (clk),
		.mag_a (dvd_s1),
		.mag_b (dvs_s1),
		.neg   (side_sp[1].negq),
		.prod  (mul_prod),
		.ovf   (mul_ovf)
	);

	cia_div #(.DATA_WIDTH(W)) u_div (
		.clk      (clk),
		.dividend (dvd_s1),
		.divisor  (dvs_s1),
		.quo      (quo),
		.rem      (rem)
	);

	// sideband follows the divider; hash and multiply results join on the way
	always_comb begin
		for (int i = 2; i <= NS; i++) begin
			side_nx[i] = side_sp[i-1];
		end
		if (side_sp[1].kind == cia_pkg::KIND_HASH)
			side_nx[2].res = hash_hi(side_sp[1].res);
		if (side_sp[MUL_IX-1].kind == cia_pkg::KIND_MUL) begin
			side_nx[MUL_IX].res = mul_prod;
			if (side_sp[MUL_IX-1].safe && mul_ovf)
				side_nx[MUL_IX].err = cia_pkg::ERR_OVF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++) vld_sp[i] <= 1'b0;
		end else begin
			vld_sp[1] <= start && !busy;
			for (int i = 2; i <= NS; i++) vld_sp[i] <= vld_sp[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_sp[1] <= side_in;
		dvd_s1     <= dvd_in;
		dvs_s1     <= dvs_in;
		for (int i = 2; i <= NS; i++) side_sp[i] <= side_nx[i];
	end

	assign fin = side_sp[NS];

	always_comb begin
		case (fin.kind)
			cia_pkg::KIND_DIV: val = fin.negq ? -quo : quo;
			cia_pkg::KIND_REM: val = fin.negr ? -rem : rem;
			cia_pkg::KIND_SHL: val = fin.res << fin.shamt;
			cia_pkg::KIND_SAR: val = W'($signed(fin.res) >>> fin.shamt);
			default:           val = fin.res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sp[NS];
		end
	end

	always_ff @(posedge clk) begin
		rsp.error  <= fin.err;
		rsp.result <= (fin.err != cia_pkg::ERR_NONE) ? 64'sd0 : 64'(signed'(val));
	end

endmodule

[src/cia_checker.sv]
// port-level checks for checked_int64_alu_core, attached with bind
// uses cia_pkg; compiled after the top level
module cia_checker #(
	parameter int DATA_WIDTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input cia_pkg::in_t  cmd,
	input logic          done,
	input cia_pkg::out_t rsp
);
	localparam int LAT = DATA_WIDTH + 2;

	// the block takes a command every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without matching command");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.error != cia_pkg::ERR_NONE) |-> rsp.result == 64'sd0)
		else $error("nonzero result with error");

	a_cmp_bool: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(cmd.kind, LAT) == cia_pkg::KIND_EQ
			|| $past(cmd.kind, LAT) == cia_pkg::KIND_NE
			|| $past(cmd.kind, LAT) == cia_pkg::KIND_GT
			|| $past(cmd.kind, LAT) == cia_pkg::KIND_GE
			|| $past(cmd.kind, LAT) == cia_pkg::KIND_LT
			|| $past(cmd.kind, LAT) == cia_pkg::KIND_LE))
		|-> rsp.result[63:1] == 63'd0)
		else $error("compare result not 0 or 1");

endmodule

bind checked_int64_alu_core cia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);

[verif/checked_int64_alu_core_tb.sv]
// self-checking testbench for checked_int64_alu_core: directed and random commands,
// results checked in order against an in-bench alu predictor; depends on cia_pkg
`timescale 1ns / 100ps

module checked_int64_alu_core_tb;

	localparam int LATENCY = 66;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cia_pkg::in_t cmd = '0;
	logic done;
	cia_pkg::out_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	checked_int64_alu_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cia_pkg::in_t pending_cmds[$];
	cia_pkg::out_t expected_rsps[$];
	bit model_safe = 1'b1;
	bit gaps_on = 1'b1;
	int failures = 0;
	int quiet_cycles = 0;

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	function automatic logic [63:0] hash64(input logic [63:0] a);
		logic [63:0] h;
		h = a;
		h = h + ~(h << cia_pkg::HASH_SH1);
		h = h ^ (h >> cia_pkg::HASH_SH2);
		h = h + (h << cia_pkg::HASH_SH3);
		h = h ^ (h >> cia_pkg::HASH_SH4);
		h = h + ~(h << cia_pkg::HASH_SH5);
		h = h ^ (h >> cia_pkg::HASH_SH6);
		return h;
	endfunction

	function automatic cia_pkg::out_t alu_predict(input cia_pkg::in_t c, input bit safe);
		cia_pkg::out_t o;
		logic signed [63:0] a, b;
		logic [63:0] r, ua, ub;
		logic signed [127:0] p;
		logic [5:0] s;
		logic [1:0] e;
		a = c.operand_a;
		b = c.operand_b;
		r = '0;
		e = cia_pkg::ERR_NONE;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		case (c.kind)
			cia_pkg::KIND_ADD: begin
				r = a + b;
				if (safe && ((a ^ r) & (b ^ r)) >> 63) e = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_SUB: begin
				r = a - b;
				if (safe && ((a ^ b) & (a ^ r)) >> 63) e = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_MUL: begin
				p = 128'(a) * 128'(b);
				r = p[63:0];
				if (safe && p != 128'(signed'(p[63:0]))) e = cia_pkg::ERR_OVF;
			end
			cia_pkg::KIND_DIV, cia_pkg::KIND_REM: begin
				if (b == 0) e = cia_pkg::ERR_DIV0;
				else if (c.kind == cia_pkg::KIND_DIV) begin
					if (safe && a == S64_MIN && b == -64'sd1) e = cia_pkg::ERR_OVF;
					else r = (a[63] != b[63]) ? -(ua / ub) : ua / ub;
				end else r = a[63] ? -(ua % ub) : ua % ub;
			end
			cia_pkg::KIND_SHL, cia_pkg::KIND_SAR: begin
				if (safe && (b < 0 || b > 63)) e = cia_pkg::ERR_SHIFT;
				else begin
					s = b[5:0];
					r = (c.kind == cia_pkg::KIND_SHL) ? a << s : a >>> s;
				end
			end
			cia_pkg::KIND_AND: r = a & b;
			cia_pkg::KIND_OR: r = a | b;
			cia_pkg::KIND_XOR: r = a ^ b;
			cia_pkg::KIND_NOT: r = ~a;
			cia_pkg::KIND_EQ: r = 64'(a == b);
			cia_pkg::KIND_NE: r = 64'(a != b);
			cia_pkg::KIND_GT: r = 64'(a > b);
			cia_pkg::KIND_GE: r = 64'(a >= b);
			cia_pkg::KIND_LT: r = 64'(a < b);
			cia_pkg::KIND_LE: r = 64'(a <= b);
			cia_pkg::KIND_MIN: r = (a < b) ? a : b;
			cia_pkg::KIND_MAX: r = (a > b) ? a : b;
			cia_pkg::KIND_HASH: r = hash64(a);
			default: r = '0;
		endcase
		o.result = (e != cia_pkg::ERR_NONE) ? '0 : r;
		o.error = e;
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = S64_MIN;
			1: v = S64_MAX;
			2: v = -64'sd1;
			3: v = 64'($urandom_range(0, 70));
			4: v = -64'($urandom_range(0, 70));
			5: v = {32'(signed'($urandom_range(0, 1) ? -1 : 0)), 32'($urandom())};
			default: v = {32'($urandom()), 32'($urandom())};
		endcase
		return v;
	endfunction

	task automatic push_cmd(input logic [4:0] k, input logic [63:0] a, input logic [63:0] b);
		cia_pkg::in_t c;
		c.kind = k;
		c.operand_a = a;
		c.operand_b = b;
		pending_cmds.push_back(c);
	endtask

	// wait until idle, settle, then write safe_mode
	task automatic write_safe(input bit v);
		while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		model_safe = v;
		cfg_valid <= 1'b0;
	endtask

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_rsps.push_back(alu_predict(cmd, model_safe));
			void'(pending_cmds.pop_front());
		end
		if (pending_cmds.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 29)) begin
			start <= 1'b1;
			cmd <= pending_cmds[0];
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cia_pkg::out_t want;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result beat result=%h error=%0d", rsp.result, rsp.error);
				failures++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.result !== want.result) begin
					$error("result: expected %h actual %h", want.result, rsp.result);
					failures++;
				end
				if (rsp.error !== want.error) begin
					$error("error: expected %0d actual %0d", want.error, rsp.error);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			logic [4:0] k;
			logic [63:0] a, b;
			k = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(20, 31))
				: 5'($urandom_range(0, 19));
			a = rand64();
			b = rand64();
			if ((k == cia_pkg::KIND_SHL || k == cia_pkg::KIND_SAR) && $urandom_range(0, 3) != 0)
				b = 64'($urandom_range(0, 63));
			push_cmd(k, a, b);
		end
		while (pending_cmds.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes and corner cases, safe mode from reset
		push_cmd(cia_pkg::KIND_ADD, S64_MAX, 64'd1);
		push_cmd(cia_pkg::KIND_SUB, S64_MIN, 64'd1);
		push_cmd(cia_pkg::KIND_MUL, S64_MIN, -64'sd1);
		push_cmd(cia_pkg::KIND_MUL, 64'h1_0000_0000, 64'h8000_0000);
		push_cmd(cia_pkg::KIND_DIV, S64_MIN, -64'sd1);
		push_cmd(cia_pkg::KIND_REM, S64_MIN, -64'sd1);
		push_cmd(cia_pkg::KIND_DIV, 64'd5, 64'd0);
		push_cmd(cia_pkg::KIND_REM, -64'sd7, 64'd2);
		push_cmd(cia_pkg::KIND_SHL, -64'sd1, 64'd64);
		push_cmd(cia_pkg::KIND_SAR, S64_MIN, -64'sd1);
		push_cmd(cia_pkg::KIND_SAR, S64_MIN, 64'd63);
		push_cmd(cia_pkg::KIND_SHL, 64'd1, 64'd63);
		for (int k = cia_pkg::KIND_AND; k <= cia_pkg::KIND_HASH; k++)
			push_cmd(5'(k), S64_MIN, S64_MAX);
		push_cmd(5'd25, S64_MAX, S64_MAX);
		push_cmd(5'd31, -64'sd1, -64'sd1);
		while (pending_cmds.size() != 0) @(posedge clk);
		write_safe(1'b0);
		push_cmd(cia_pkg::KIND_ADD, S64_MAX, 64'd1);
		push_cmd(cia_pkg::KIND_DIV, S64_MIN, -64'sd1);
		push_cmd(cia_pkg::KIND_DIV, 64'd5, 64'd0);
		push_cmd(cia_pkg::KIND_SHL, 64'd3, 64'd65);
		push_cmd(cia_pkg::KIND_SAR, S64_MIN, -64'sd1);
		random_phase(650);
		write_safe(1'b1);
		gaps_on = 1'b0;
		random_phase(300);
		gaps_on = 1'b1;
		random_phase(350);
		// hold off until everything has drained
		while (expected_rsps.size() != 0) @(posedge clk);
		write_safe(1'b0);
		random_phase(300);
		write_safe(1'b1);
		random_phase(320);
		while (start || expected_rsps.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (failures == 0 && expected_rsps.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
